// ===== src/tesp_pkg.sv =====
// Shared types, codes and helpers for the timed event stream parser.
// No dependencies; used by tesp_decode and timed_event_stream_parser.
`default_nettype none

package tesp_pkg;

    localparam int TICK_WIDTH_DEFAULT = 32;

    // parse phase codes
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_IDLE   = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_SECOND = 3'd3;
    localparam logic [2:0] PH_ENDED  = 3'd4;

    // event kinds
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_DELAY   = 3'd1;
    localparam logic [2:0] KIND_NOTEOFF = 3'd2;
    localparam logic [2:0] KIND_NOTEON  = 3'd3;
    localparam logic [2:0] KIND_CONTROL = 3'd4;
    localparam logic [2:0] KIND_PROGRAM = 3'd5;
    localparam logic [2:0] KIND_BEND    = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    // status bytes and nibbles
    localparam logic [7:0] ST_DELAY_LO   = 8'hD0;
    localparam logic [7:0] ST_DELAY_HI   = 8'hDD;
    localparam logic [7:0] ST_DELAY_BYTE = 8'hDE;
    localparam logic [7:0] ST_DELAY_WORD = 8'hDF;
    localparam logic [7:0] ST_END        = 8'hFC;
    localparam logic [3:0] HI_NOTEOFF    = 4'h8;
    localparam logic [3:0] HI_NOTEON     = 4'h9;
    localparam logic [3:0] HI_CONTROL    = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_BEND       = 4'hE;

    localparam int TDATA_OUT_WIDTH = 88;

    typedef struct packed {
        logic        valid;
        logic [2:0]  event_kind;
        logic [3:0]  channel;
        logic [7:0]  first_param;
        logic [7:0]  second_param;
        logic [15:0] bend_value;
        logic [15:0] delay_ticks;
        logic [31:0] target_tick;
    } result_t;

    // channel-message kind for a status byte, KIND_HEADER when not one
    function automatic logic [2:0] kind_of(input logic [7:0] st);
        logic [2:0] k;
        begin
            unique case (st[7:4])
                HI_NOTEOFF: k = KIND_NOTEOFF;
                HI_NOTEON:  k = KIND_NOTEON;
                HI_CONTROL: k = KIND_CONTROL;
                HI_PROGRAM: k = KIND_PROGRAM;
                HI_BEND:    k = KIND_BEND;
                default:    k = KIND_HEADER;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/tesp_decode.sv =====
// Single-pass byte decoder: next parse state and result for one byte.
// Depends on tesp_pkg.
`default_nettype none

module tesp_decode #(
    parameter int TICK_WIDTH = tesp_pkg::TICK_WIDTH_DEFAULT
) (
    input  wire logic [2:0]            phase_i,
    input  wire logic [7:0]            status_i,
    input  wire logic [7:0]            first_i,
    input  wire logic [TICK_WIDTH-1:0] sum_i,
    input  wire logic [7:0]            byte_i,
    output      logic [2:0]            phase_o,
    output      logic [7:0]            status_o,
    output      logic [7:0]            first_o,
    output      logic [TICK_WIDTH-1:0] sum_o,
    output      tesp_pkg::result_t     res_o
);

    logic        do_delay;
    logic [15:0] delay_amt;
    logic        do_finish;
    logic [7:0]  fin_a;
    logic [7:0]  fin_b;
    logic [2:0]  fin_kind;
    logic [63:0] sum_ext;

    always_comb begin
        phase_o   = phase_i;
        status_o  = status_i;
        first_o   = first_i;
        do_delay  = 1'b0;
        delay_amt = 16'd0;
        do_finish = 1'b0;
        fin_a     = byte_i;
        fin_b     = 8'd0;
        res_o     = '0;

        unique case (phase_i)
            tesp_pkg::PH_HEADER: begin
                phase_o           = tesp_pkg::PH_IDLE;
                res_o.valid       = 1'b1;
                res_o.event_kind  = tesp_pkg::KIND_HEADER;
                res_o.first_param = byte_i;
            end
            tesp_pkg::PH_IDLE: begin
                if (byte_i >= tesp_pkg::ST_DELAY_LO && byte_i <= tesp_pkg::ST_DELAY_HI) begin
                    do_delay  = 1'b1;
                    delay_amt = {12'd0, byte_i[3:0]} + 16'd1;
                end else if (byte_i == tesp_pkg::ST_DELAY_BYTE ||
                             byte_i == tesp_pkg::ST_DELAY_WORD) begin
                    status_o = byte_i;
                    phase_o  = tesp_pkg::PH_FIRST;
                end else if (byte_i == tesp_pkg::ST_END) begin
                    phase_o          = tesp_pkg::PH_ENDED;
                    res_o.valid      = 1'b1;
                    res_o.event_kind = tesp_pkg::KIND_END;
                end else if (tesp_pkg::kind_of(byte_i) != tesp_pkg::KIND_HEADER) begin
                    status_o = byte_i;
                    phase_o  = tesp_pkg::PH_FIRST;
                end
            end
            tesp_pkg::PH_FIRST: begin
                if (status_i == tesp_pkg::ST_DELAY_BYTE) begin
                    phase_o   = tesp_pkg::PH_IDLE;
                    do_delay  = 1'b1;
                    delay_amt = {8'd0, byte_i} + 16'd1;
                end else if (status_i[7:4] == tesp_pkg::HI_PROGRAM) begin
                    do_finish = 1'b1;
                end else begin
                    first_o = byte_i;
                    phase_o = tesp_pkg::PH_SECOND;
                end
            end
            tesp_pkg::PH_SECOND: begin
                if (status_i == tesp_pkg::ST_DELAY_WORD) begin
                    phase_o   = tesp_pkg::PH_IDLE;
                    do_delay  = 1'b1;
                    delay_amt = {8'd0, first_i} + {1'b0, byte_i, 7'd0} + 16'd1;
                end else begin
                    do_finish = 1'b1;
                    fin_a     = first_i;
                    fin_b     = byte_i;
                end
            end
            default: phase_o = tesp_pkg::PH_ENDED;
        endcase

        fin_kind = tesp_pkg::kind_of(status_i);
        if (do_finish) begin
            phase_o            = tesp_pkg::PH_IDLE;
            res_o.valid        = 1'b1;
            res_o.event_kind   = fin_kind;
            res_o.channel      = status_i[3:0];
            res_o.first_param  = fin_a;
            // program change carries one byte only
            res_o.second_param = (fin_kind == tesp_pkg::KIND_PROGRAM) ? 8'd0 : fin_b;
            if (fin_kind == tesp_pkg::KIND_BEND)
                res_o.bend_value = {8'd0, fin_a} + {1'b0, fin_b, 7'd0};
        end

        sum_o = do_delay ? (sum_i + TICK_WIDTH'(delay_amt)) : sum_i;
        if (do_delay) begin
            res_o.valid       = 1'b1;
            res_o.event_kind  = tesp_pkg::KIND_DELAY;
            res_o.delay_ticks = delay_amt;
        end
        sum_ext           = 64'(sum_o);
        res_o.target_tick = sum_ext[31:0];
    end

endmodule

`default_nettype wire

// ===== src/timed_event_stream_parser.sv =====
// Top level of the timed event stream parser: input register, parse state,
// result register and stream handshakes. Depends on tesp_pkg, tesp_decode.
`default_nettype none

// Accepts one byte of a timed event file per transfer and returns at most one
// event per byte. The first byte after reset is a header event; later bytes are
// decoded as delays, channel messages or the end code, after which all input is
// swallowed silently. A byte is taken every cycle when the output is drained;
// each byte passes an input register, the combinational phase decode and tick
// add, and the result register, which offers its event on m_tvalid.
// The running tick sum is TICK_WIDTH bits wide and reported as its low 32 bits.
module timed_event_stream_parser #(
    parameter int TICK_WIDTH = tesp_pkg::TICK_WIDTH_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [7:0]                           s_tdata,  // [7:0] stream_byte
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // [2:0] event_kind, [6:3] channel, [14:7] first_param, [22:15] second_param,
    // [38:23] bend_value, [54:39] delay_ticks, [86:55] target_tick, [87] zero
    output      logic [tesp_pkg::TDATA_OUT_WIDTH-1:0] m_tdata
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic [2:0]            phase_reg, phase_next;
    logic [7:0]            status_reg, status_next;
    logic [7:0]            first_reg, first_next;
    logic [TICK_WIDTH-1:0] sum_reg, sum_next;
    logic                  out_valid_reg;
    tesp_pkg::result_t     out_reg;
    tesp_pkg::result_t     res;
    logic                  advance;

    // decode stage moves when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tesp_decode #(.TICK_WIDTH(TICK_WIDTH)) u_decode (
        .phase_i  (phase_reg),
        .status_i (status_reg),
        .first_i  (first_reg),
        .sum_i    (sum_reg),
        .byte_i   (in_byte_reg),
        .phase_o  (phase_next),
        .status_o (status_next),
        .first_o  (first_next),
        .sum_o    (sum_next),
        .res_o    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= tesp_pkg::PH_HEADER;
            status_reg    <= 8'd0;
            first_reg     <= 8'd0;
            sum_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance) begin
                phase_reg     <= phase_next;
                status_reg    <= status_next;
                first_reg     <= first_next;
                sum_reg       <= sum_next;
                out_valid_reg <= res.valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.target_tick, out_reg.delay_ticks, out_reg.bend_value,
                       out_reg.second_param, out_reg.first_param, out_reg.channel,
                       out_reg.event_kind};

`ifndef SYNTHESIS
    a_end_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tesp_pkg::PH_ENDED |=> phase_reg == tesp_pkg::PH_ENDED)
        else $error("parser left the ended phase");

    a_sum_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(sum_reg))
        else $error("tick sum changed without a decoded byte");

    a_delay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.event_kind == tesp_pkg::KIND_DELAY
        |-> out_reg.delay_ticks != 16'd0)
        else $error("delay event with zero ticks");

    a_bend_only_for_bend: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.event_kind != tesp_pkg::KIND_BEND
        |-> out_reg.bend_value == 16'd0)
        else $error("bend value on a non-bend event");

    a_no_stall_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for timed_event_stream_parser: directed byte table, then random
// event messages, each result compared with an in-bench decoder or a fixed table row. Depends on tesp_pkg.
`timescale 1ns / 1ps

module tb_top;
    import tesp_pkg::*;

    localparam int RANDOM_ITEMS     = 1400;
    localparam int QUIET_FROM       = 500;
    localparam int QUIET_TO         = 650;
    localparam int PAUSE_AT         = 900;
    localparam int LONG_HOLD_AFTER  = 250;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 20;
    localparam int TIMEOUT_CYCLES   = 600_000;
    localparam int MAX_PRINTED      = 30;

    // same layout as m_tdata[86:0], last field in the lowest bits
    typedef struct packed {
        logic [31:0] target_tick;
        logic [15:0] delay_ticks;
        logic [15:0] bend_value;
        logic [7:0]  second_param;
        logic [7:0]  first_param;
        logic [3:0]  channel;
        logic [2:0]  event_kind;
    } parsed_event_t;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_LITERAL} row_check_t;

    typedef struct packed {
        logic [7:0]    stim;
        row_check_t    check;
        parsed_event_t fixed;
    } directed_row_t;

    localparam parsed_event_t NO_EVENT = '0;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_OUT_WIDTH-1:0] m_tdata;

    // decoder state
    logic [2:0]  parse_state = PH_HEADER;
    logic [7:0]  status_hold = 8'h00;
    logic [7:0]  first_hold  = 8'h00;
    logic [31:0] tick_total  = 32'd0;

    parsed_event_t   expected_events[$];
    directed_row_t   directed_table[$];
    int unsigned     mismatch_count = 0;
    int unsigned     events_checked = 0;
    int unsigned     bytes_sent     = 0;
    bit              quiet_stretch  = 1'b0;
    bit              long_hold_done = 1'b0;

    timed_event_stream_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic parsed_event_t mk_event(input logic [2:0] kind, input logic [3:0] chan,
                                               input logic [7:0] p1, input logic [7:0] p2,
                                               input logic [15:0] bend, input logic [15:0] ticks,
                                               input logic [31:0] target);
        parsed_event_t ev;
        ev.event_kind   = kind;
        ev.channel      = chan;
        ev.first_param  = p1;
        ev.second_param = p2;
        ev.bend_value   = bend;
        ev.delay_ticks  = ticks;
        ev.target_tick  = target;
        return ev;
    endfunction

    function automatic logic [2:0] channel_kind(input logic [7:0] st);
        case (st[7:4])
            HI_NOTEOFF: return KIND_NOTEOFF;
            HI_NOTEON:  return KIND_NOTEON;
            HI_CONTROL: return KIND_CONTROL;
            HI_PROGRAM: return KIND_PROGRAM;
            HI_BEND:    return KIND_BEND;
            default:    return KIND_HEADER;
        endcase
    endfunction

    function automatic parsed_event_t channel_event(input logic [7:0] p1, input logic [7:0] p2);
        logic [2:0]  kind;
        logic [7:0]  p2_eff;
        logic [15:0] bend;
        kind   = channel_kind(status_hold);
        p2_eff = (kind == KIND_PROGRAM) ? 8'h00 : p2;
        bend   = (kind == KIND_BEND) ? 16'(p1) + (16'(p2_eff) << 7) : 16'd0;
        parse_state = PH_IDLE;
        return mk_event(kind, status_hold[3:0], p1, p2_eff, bend, 16'd0, tick_total);
    endfunction

    // advances the decoder by one byte; returns 1 when the byte completes an event
    function automatic bit decode_byte(input logic [7:0] b, output parsed_event_t ev);
        logic [15:0] ticks;
        ev    = NO_EVENT;
        ticks = 16'd0;
        case (parse_state)
            PH_HEADER: begin
                parse_state = PH_IDLE;
                ev = mk_event(KIND_HEADER, 4'h0, b, 8'h00, 16'd0, 16'd0, tick_total);
                return 1'b1;
            end
            PH_IDLE: begin
                if (b >= ST_DELAY_LO && b <= ST_DELAY_HI) begin
                    ticks = 16'(b[3:0]) + 16'd1;
                end else if (b == ST_DELAY_BYTE || b == ST_DELAY_WORD
                             || channel_kind(b) != KIND_HEADER) begin
                    status_hold = b;
                    parse_state = PH_FIRST;
                end else if (b == ST_END) begin
                    parse_state = PH_ENDED;
                    ev = mk_event(KIND_END, 4'h0, 8'h00, 8'h00, 16'd0, 16'd0, tick_total);
                    return 1'b1;
                end
            end
            PH_FIRST: begin
                if (status_hold == ST_DELAY_BYTE) begin
                    parse_state = PH_IDLE;
                    ticks = 16'(b) + 16'd1;
                end else if (status_hold[7:4] == HI_PROGRAM) begin
                    ev = channel_event(b, 8'h00);
                    return 1'b1;
                end else begin
                    first_hold  = b;
                    parse_state = PH_SECOND;
                end
            end
            PH_SECOND: begin
                parse_state = PH_IDLE;
                if (status_hold == ST_DELAY_WORD) begin
                    ticks = 16'(first_hold) + (16'(b) << 7) + 16'd1;
                end else begin
                    ev = channel_event(first_hold, b);
                    return 1'b1;
                end
            end
            default: ;
        endcase
        if (ticks != 16'd0) begin
            tick_total = tick_total + 32'(ticks);
            ev = mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, ticks, tick_total);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // extremes show up more often than a flat draw would give them
    function automatic logic [7:0] param_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] channel_status();
        logic [7:0] st;
        case ($urandom_range(0, 4))
            0:       st[7:4] = HI_NOTEOFF;
            1:       st[7:4] = HI_NOTEON;
            2:       st[7:4] = HI_CONTROL;
            3:       st[7:4] = HI_PROGRAM;
            default: st[7:4] = HI_BEND;
        endcase
        st[3:0] = 4'($urandom_range(0, 15));
        return st;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
    endtask

    task automatic add_row(input logic [7:0] stim, input row_check_t check,
                           input parsed_event_t fixed);
        directed_row_t row;
        row.stim  = stim;
        row.check = check;
        row.fixed = fixed;
        directed_table.push_back(row);
    endtask

    // one input transfer, then the decoder step and the expectation it leaves
    task automatic feed_byte(input logic [7:0] b, input row_check_t check,
                             input parsed_event_t fixed);
        int            gap;
        bit            has;
        parsed_event_t ev;
        gap = quiet_stretch ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        has = decode_byte(b, ev);
        bytes_sent++;
        case (check)
            CHK_PREDICT: if (has) expected_events.push_back(ev);
            CHK_LITERAL: expected_events.push_back(fixed);
            default: ;
        endcase
    endtask

    // random part must not reach the end code while idle, or the block goes silent
    task automatic feed_data(input logic [7:0] b);
        feed_byte((parse_state == PH_IDLE && b == ST_END) ? 8'hF9 : b, CHK_PREDICT, NO_EVENT);
    endtask

    task automatic send_random_message();
        int         pick;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            feed_data(ST_DELAY_LO + 8'($urandom_range(0, 13)));
        end else if (pick < 20) begin
            feed_data(ST_DELAY_BYTE);
            feed_data(param_byte());
        end else if (pick < 28) begin
            feed_data(ST_DELAY_WORD);
            feed_data(param_byte());
            feed_data(param_byte());
        end else if (pick < 85) begin
            st = channel_status();
            feed_data(st);
            feed_data(param_byte());
            if (st[7:4] != HI_PROGRAM)
                feed_data(param_byte());
        end else if (pick < 95) begin
            case ($urandom_range(0, 2))
                0:       st = 8'($urandom_range(8'h00, 8'h7F));
                1:       st = {4'hA, 4'($urandom_range(0, 15))};
                default: st = {4'hF, 4'($urandom_range(0, 15))};
            endcase
            feed_data(st);
        end else begin
            // message cut short: the next status byte gets taken as data
            feed_data(channel_status());
            feed_data(8'($urandom_range(8'h80, 8'hFB)));
        end
    endtask

    initial begin : stimulus
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(8'hFF, CHK_LITERAL,
                mk_event(KIND_HEADER, 4'h0, 8'hFF, 8'h00, 16'd0, 16'd0, 32'd0));
        add_row(ST_DELAY_LO, CHK_LITERAL,
                mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, 16'd1, 32'd1));
        add_row(ST_DELAY_HI, CHK_LITERAL,
                mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, 16'd14, 32'd15));
        // byte delay of 255 is reported as 256, not wrapped
        add_row(ST_DELAY_BYTE, CHK_SILENT, NO_EVENT);
        add_row(8'hFF, CHK_LITERAL,
                mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, 16'd256, 32'd271));
        add_row(ST_DELAY_BYTE, CHK_SILENT, NO_EVENT);
        add_row(8'h00, CHK_LITERAL,
                mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, 16'd1, 32'd272));
        add_row(ST_DELAY_WORD, CHK_SILENT, NO_EVENT);
        add_row(8'hFF, CHK_SILENT, NO_EVENT);
        add_row(8'hFF, CHK_LITERAL,
                mk_event(KIND_DELAY, 4'h0, 8'h00, 8'h00, 16'd0, 16'd32896, 32'd33168));
        // unknown status bytes are skipped
        add_row(8'h00, CHK_SILENT, NO_EVENT);
        add_row(8'h7F, CHK_SILENT, NO_EVENT);
        add_row(8'hA5, CHK_SILENT, NO_EVENT);
        add_row(8'hF0, CHK_SILENT, NO_EVENT);
        // full 8-bit parameters, note on with zero velocity, every message kind
        add_row(8'h80, CHK_PREDICT, NO_EVENT);
        add_row(8'h00, CHK_PREDICT, NO_EVENT);
        add_row(8'hFF, CHK_PREDICT, NO_EVENT);
        add_row(8'h9F, CHK_PREDICT, NO_EVENT);
        add_row(8'h40, CHK_PREDICT, NO_EVENT);
        add_row(8'h00, CHK_PREDICT, NO_EVENT);
        add_row(8'hBA, CHK_PREDICT, NO_EVENT);
        add_row(8'h7F, CHK_PREDICT, NO_EVENT);
        add_row(8'h80, CHK_PREDICT, NO_EVENT);
        add_row(8'hC3, CHK_PREDICT, NO_EVENT);
        add_row(ST_END, CHK_PREDICT, NO_EVENT);
        add_row(8'hEF, CHK_PREDICT, NO_EVENT);
        add_row(8'hFF, CHK_PREDICT, NO_EVENT);
        add_row(8'hFF, CHK_PREDICT, NO_EVENT);

        foreach (directed_table[i])
            feed_byte(directed_table[i].stim, directed_table[i].check, directed_table[i].fixed);

        while (bytes_sent < directed_table.size() + RANDOM_ITEMS) begin
            quiet_stretch = (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO);
            if (bytes_sent >= PAUSE_AT && bytes_sent < PAUSE_AT + 4) begin
                // let the block drain completely before going on
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (expected_events.size() != 0);
            end
            send_random_message();
        end
        quiet_stretch = 1'b0;

        // end code from idle, then bytes the block must swallow
        while (parse_state != PH_IDLE)
            feed_data(param_byte());
        feed_byte(ST_END, CHK_PREDICT, NO_EVENT);
        feed_byte(ST_DELAY_LO, CHK_PREDICT, NO_EVENT);
        feed_byte(8'h90, CHK_PREDICT, NO_EVENT);
        feed_byte(8'h00, CHK_PREDICT, NO_EVENT);
        feed_byte(8'hFF, CHK_PREDICT, NO_EVENT);
        s_tvalid <= 1'b0;

        while (expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!long_hold_done && events_checked >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_stretch && $urandom_range(0, 3) == 0) begin
                stall = 1 + idle_len();
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        parsed_event_t got;
        parsed_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[86:0];
            if (m_tdata[87] !== 1'b0)
                report_mismatch("pad bit", 0, m_tdata[87]);
            if (expected_events.size() == 0) begin
                report_mismatch("transfer with nothing pending, event_kind", 0, got.event_kind);
            end else begin
                want = expected_events.pop_front();
                if (got.event_kind !== want.event_kind)
                    report_mismatch("event_kind", want.event_kind, got.event_kind);
                if (got.channel !== want.channel)
                    report_mismatch("channel", want.channel, got.channel);
                if (got.first_param !== want.first_param)
                    report_mismatch("first_param", want.first_param, got.first_param);
                if (got.second_param !== want.second_param)
                    report_mismatch("second_param", want.second_param, got.second_param);
                if (got.bend_value !== want.bend_value)
                    report_mismatch("bend_value", want.bend_value, got.bend_value);
                if (got.delay_ticks !== want.delay_ticks)
                    report_mismatch("delay_ticks", want.delay_ticks, got.delay_ticks);
                if (got.target_tick !== want.target_tick)
                    report_mismatch("target_tick", want.target_tick, got.target_tick);
            end
            events_checked++;
        end
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
